>>> design/wlm_pkg.sv
// Package for the windowed latency monitor bank.
// Holds field widths, item structs, state codes and per-monitor record layout.
// No dependencies.
`default_nettype none

package wlm_pkg;

   localparam int IDX_W   = 6;
   localparam int TIME_W  = 48;
   localparam int CNT_W   = 10;
   localparam int TOTAL_W = 58;

   // Restoring divide: one quotient bit per step over the whole total.
   localparam int DIV_STEPS = TOTAL_W;
   localparam int DIV_CNT_W = 6;

   localparam logic [CNT_W-1:0] WINDOW_LENGTH_RESET = 10'd500;

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_STOP  = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [IDX_W-1:0]  monitor_index;
      logic [TIME_W-1:0] timestamp;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  report_monitor;
      logic [TIME_W-1:0] min_duration;
      logic [TIME_W-1:0] max_duration;
      logic [TIME_W-1:0] mean_duration;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0]  win_min;
      logic [TIME_W-1:0]  win_max;
      logic [TOTAL_W-1:0] win_total;
      logic [CNT_W-1:0]   stop_count;
   } stats_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DUR,
      ST_MIN,
      ST_MAX,
      ST_ADD,
      ST_WB,
      ST_DIV
   } state_type;

endpackage

`default_nettype wire

>>> design/windowed_latency_monitor_bank.sv
// Top level of the windowed latency monitor bank.
// Depends on wlm_pkg (item structs, widths, state codes).
//
// Usage:
//   Drive req_item and raise start; the item is taken at the edge where start
//   is high and busy is low. Each item is a start or stop event for one
//   monitor, stamped with the current time. Every window_length completed
//   intervals of a monitor produce one report item on rsp_item, marked by
//   rsp_valid for exactly one cycle. The receiver cannot hold reports off.
//   window_length is written over the csr_ channel (always ready); write it
//   only while the block is idle. A length of zero acts as one.
// Sequencing:
//   Duration, compare, total and divide steps share one 58-bit add/subtract
//   unit stepped by a small sequencer. A start, ignored or out-of-range event
//   visits ST_DUR only; a stop inside a window goes on through ST_MIN, ST_MAX,
//   ST_ADD and ST_WB; a closing stop then runs the bit-serial mean divide in
//   ST_DIV, and its report appears the cycle busy falls.
// Reset:
//   Synchronous reset marks every monitor idle with an empty window and loads
//   window_length with 500. The per-monitor statistics memory needs no
//   clearing pass: a valid bit per entry makes untouched entries read empty.
`default_nettype none

module windowed_latency_monitor_bank #(
   parameter int MONITORS = 64
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire wlm_pkg::req_type req_item,
   output logic                 rsp_valid,
   output wlm_pkg::rsp_type     rsp_item,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [wlm_pkg::CNT_W-1:0] csr_data
);

   localparam int AW = (MONITORS > 1) ? $clog2(MONITORS) : 1;

   // Memories: window statistics and start stamps, one entry per monitor.
   wlm_pkg::stats_type                stats_mem [MONITORS];
   logic [wlm_pkg::TIME_W-1:0]        stamp_mem [MONITORS];

   wlm_pkg::state_type                state_ff, state_in;
   wlm_pkg::req_type                  req_ff;
   logic [AW-1:0]                     addr_ff;
   logic                              in_range_ff;
   wlm_pkg::stats_type                stats_q_ff;
   logic [wlm_pkg::TIME_W-1:0]        stamp_q_ff;
   logic [MONITORS-1:0]               running_ff;
   logic [MONITORS-1:0]               stats_valid_ff;
   logic [wlm_pkg::CNT_W-1:0]         window_length_ff;

   // Working copy of the addressed monitor's window.
   logic [wlm_pkg::TIME_W-1:0]        dur_ff;
   logic [wlm_pkg::TIME_W-1:0]        min_ff;
   logic [wlm_pkg::TIME_W-1:0]        max_ff;
   logic [wlm_pkg::TOTAL_W-1:0]       tot_ff;
   logic [wlm_pkg::CNT_W-1:0]         cnt_ff;

   // Divider state.
   logic [wlm_pkg::CNT_W-1:0]         rem_ff;
   logic [wlm_pkg::TOTAL_W-1:0]       quo_ff;
   logic [wlm_pkg::DIV_CNT_W-1:0]     div_cnt_ff;

   logic                              rsp_valid_ff, rsp_valid_in;
   wlm_pkg::rsp_type                  rsp_ff;

   logic                              accept;
   logic [AW-1:0]                     req_addr;
   logic [wlm_pkg::CNT_W-1:0]         len;
   logic                              running_cur;
   logic                              window_end;

   // Shared add/subtract unit.
   logic [wlm_pkg::TOTAL_W-1:0]       alu_a, alu_b;
   logic                              alu_sub;
   logic [wlm_pkg::TOTAL_W:0]         alu_sum;
   logic                              alu_borrow;

   logic                              stamp_we, stats_we, stats_clear;
   logic                              load_work, take_min, take_max, take_add;
   logic                              div_load, div_step;
   logic [wlm_pkg::TOTAL_W-1:0]       quo_next;
   logic [wlm_pkg::CNT_W:0]           div_trial;

   assign busy      = (state_ff != wlm_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign req_addr  = AW'(req_item.monitor_index);
   assign len       = (window_length_ff == '0) ? wlm_pkg::CNT_W'(1) : window_length_ff;
   assign running_cur = running_ff[addr_ff];
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Window closes when the count wraps or reaches or passes the current length.
   assign window_end = (cnt_ff == '0) || (cnt_ff >= len);

   assign div_trial = {rem_ff, quo_ff[wlm_pkg::TOTAL_W-1]};

   always_comb begin
      alu_sum    = {1'b0, alu_a} + ({1'b0, alu_b} ^ {(wlm_pkg::TOTAL_W+1){alu_sub}})
                   + (wlm_pkg::TOTAL_W+1)'(alu_sub);
      alu_borrow = alu_sum[wlm_pkg::TOTAL_W];
      quo_next   = {quo_ff[wlm_pkg::TOTAL_W-2:0], !alu_borrow};
   end

   // Sequencer: next state, unit operand select and strobes.
   always_comb begin
      state_in     = state_ff;
      alu_a        = '0;
      alu_b        = '0;
      alu_sub      = 1'b1;
      stamp_we     = 1'b0;
      stats_we     = 1'b0;
      stats_clear  = 1'b0;
      load_work    = 1'b0;
      take_min     = 1'b0;
      take_max     = 1'b0;
      take_add     = 1'b0;
      div_load     = 1'b0;
      div_step     = 1'b0;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         wlm_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = wlm_pkg::ST_DUR;
            end
         end
         wlm_pkg::ST_DUR: begin
            // Elapsed ticks, modulo the timestamp width.
            alu_a = wlm_pkg::TOTAL_W'(req_ff.timestamp);
            alu_b = wlm_pkg::TOTAL_W'(stamp_q_ff);
            state_in = wlm_pkg::ST_IDLE;
            if (in_range_ff) begin
               if (req_ff.mode == wlm_pkg::MODE_START) begin
                  stamp_we = !running_cur;
               end else if (running_cur) begin
                  load_work = 1'b1;
                  state_in  = wlm_pkg::ST_MIN;
               end
            end
         end
         wlm_pkg::ST_MIN: begin
            alu_a    = wlm_pkg::TOTAL_W'(dur_ff);
            alu_b    = wlm_pkg::TOTAL_W'(min_ff);
            take_min = alu_borrow;
            state_in = wlm_pkg::ST_MAX;
         end
         wlm_pkg::ST_MAX: begin
            alu_a    = wlm_pkg::TOTAL_W'(max_ff);
            alu_b    = wlm_pkg::TOTAL_W'(dur_ff);
            take_max = alu_borrow;
            state_in = wlm_pkg::ST_ADD;
         end
         wlm_pkg::ST_ADD: begin
            alu_a    = tot_ff;
            alu_b    = wlm_pkg::TOTAL_W'(dur_ff);
            alu_sub  = 1'b0;
            take_add = 1'b1;
            state_in = wlm_pkg::ST_WB;
         end
         wlm_pkg::ST_WB: begin
            if (window_end) begin
               stats_clear = 1'b1;
               div_load    = 1'b1;
               state_in    = wlm_pkg::ST_DIV;
            end else begin
               stats_we = 1'b1;
               state_in = wlm_pkg::ST_IDLE;
            end
         end
         wlm_pkg::ST_DIV: begin
            // Trial subtract of the divisor from the shifted remainder.
            alu_a    = wlm_pkg::TOTAL_W'(div_trial);
            alu_b    = wlm_pkg::TOTAL_W'(len);
            div_step = 1'b1;
            if (div_cnt_ff == '0) begin
               rsp_valid_in = 1'b1;
               state_in     = wlm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wlm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wlm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control state: run flags, entry valid bits, config, report strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff       <= '0;
         stats_valid_ff   <= '0;
         window_length_ff <= wlm_pkg::WINDOW_LENGTH_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            window_length_ff <= csr_data;
         end
         if (stamp_we) begin
            running_ff[addr_ff] <= 1'b1;
         end
         if (load_work) begin
            running_ff[addr_ff] <= 1'b0;
         end
         if (stats_we) begin
            stats_valid_ff[addr_ff] <= 1'b1;
         end
         if (stats_clear) begin
            stats_valid_ff[addr_ff] <= 1'b0;
         end
      end
   end

   // Memories: registered read at accept, write back from the sequencer.
   always_ff @(posedge clock) begin
      if (accept) begin
         stats_q_ff <= stats_mem[req_addr];
         stamp_q_ff <= stamp_mem[req_addr];
      end
      if (stamp_we) begin
         stamp_mem[addr_ff] <= req_ff.timestamp;
      end
      if (stats_we) begin
         stats_mem[addr_ff] <= '{win_min: min_ff, win_max: max_ff,
                                win_total: tot_ff, stop_count: cnt_ff};
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff      <= req_item;
         addr_ff     <= req_addr;
         in_range_ff <= (32'(req_item.monitor_index) < MONITORS);
      end
      if (load_work) begin
         dur_ff <= alu_sum[wlm_pkg::TIME_W-1:0];
         if (stats_valid_ff[addr_ff]) begin
            min_ff <= stats_q_ff.win_min;
            max_ff <= stats_q_ff.win_max;
            tot_ff <= stats_q_ff.win_total;
            cnt_ff <= stats_q_ff.stop_count;
         end else begin
            // Untouched entry reads as an empty window.
            min_ff <= '1;
            max_ff <= '0;
            tot_ff <= '0;
            cnt_ff <= '0;
         end
      end
      if (take_min) begin
         min_ff <= dur_ff;
      end
      if (take_max) begin
         max_ff <= dur_ff;
      end
      if (take_add) begin
         tot_ff <= alu_sum[wlm_pkg::TOTAL_W-1:0];
         cnt_ff <= cnt_ff + wlm_pkg::CNT_W'(1);
      end
      if (div_load) begin
         rem_ff     <= '0;
         quo_ff     <= tot_ff;
         div_cnt_ff <= wlm_pkg::DIV_CNT_W'(wlm_pkg::DIV_STEPS - 1);
      end
      if (div_step) begin
         rem_ff     <= alu_borrow ? div_trial[wlm_pkg::CNT_W-1:0]
                                  : alu_sum[wlm_pkg::CNT_W-1:0];
         quo_ff     <= quo_next;
         div_cnt_ff <= div_cnt_ff - wlm_pkg::DIV_CNT_W'(1);
      end
      if (rsp_valid_in) begin
         rsp_ff.report_monitor <= req_ff.monitor_index;
         rsp_ff.min_duration   <= min_ff;
         rsp_ff.max_duration   <= max_ff;
         rsp_ff.mean_duration  <= quo_next[wlm_pkg::TIME_W-1:0];
      end
   end

   // A report only ever follows the last divide step.
   a_rsp_after_div : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == wlm_pkg::ST_DIV))
      else $error("report not preceded by divide");

   // A report strobe lasts one cycle.
   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("report strobe longer than one cycle");

   // Every closed window holds at least one interval, so min never exceeds max.
   a_min_le_max : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.min_duration <= rsp_ff.max_duration))
      else $error("report min above max");

   // A counted stop leaves its monitor idle.
   a_stop_clears_run : assert property (@(posedge clock) disable iff (reset)
      load_work |=> !running_ff[addr_ff])
      else $error("monitor still running after stop");

   // At most one memory is written in a cycle.
   a_one_write : assert property (@(posedge clock) disable iff (reset)
      $onehot0({stamp_we, stats_we, stats_clear}))
      else $error("overlapping memory writes");

endmodule

`default_nettype wire

>>> sim/wlm_checker.sv
// Checker for the windowed latency monitor bank: watches the event, report and
// window-length channels, predicts each report and compares it field by field.
// Depends on wlm_pkg for the item structs, widths and mode codes.
`timescale 1ns / 1ps

module wlm_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  wlm_pkg::req_type              req_item,
   input  logic                          rsp_valid,
   input  wlm_pkg::rsp_type              rsp_item,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [wlm_pkg::CNT_W-1:0]     csr_data,
   output int                            mismatch_count,
   output int                            reports_outstanding
);

   localparam int BANK_SIZE = 64;

   logic [wlm_pkg::CNT_W-1:0]   window_len;
   bit                          timing      [BANK_SIZE];
   logic [wlm_pkg::TIME_W-1:0]  opened_at   [BANK_SIZE];
   logic [wlm_pkg::CNT_W-1:0]   closed_cnt  [BANK_SIZE];
   logic [wlm_pkg::TIME_W-1:0]  shortest    [BANK_SIZE];
   logic [wlm_pkg::TIME_W-1:0]  longest     [BANK_SIZE];
   logic [wlm_pkg::TOTAL_W-1:0] elapsed_sum [BANK_SIZE];
   wlm_pkg::rsp_type            expected_reports[$];

   task automatic clear_window_stats(int m);
      closed_cnt[m]  = '0;
      shortest[m]    = '1;
      longest[m]     = '0;
      elapsed_sum[m] = '0;
   endtask

   // Fold one accepted event into the bank; queue a report when a window closes.
   task automatic track_event(wlm_pkg::req_type ev);
      int                          m;
      logic [wlm_pkg::TIME_W-1:0]  dur;
      logic [wlm_pkg::CNT_W-1:0]   cnt;
      logic [wlm_pkg::TOTAL_W-1:0] divisor;
      wlm_pkg::rsp_type            rep;
      m = int'(ev.monitor_index);
      if (ev.mode == wlm_pkg::MODE_START) begin
         if (!timing[m]) begin
            timing[m]    = 1'b1;
            opened_at[m] = ev.timestamp;
         end
         return;
      end
      if (!timing[m]) return;
      timing[m] = 1'b0;
      dur = ev.timestamp - opened_at[m];
      if (dur < shortest[m]) shortest[m] = dur;
      if (dur > longest[m]) longest[m] = dur;
      elapsed_sum[m] = elapsed_sum[m] + wlm_pkg::TOTAL_W'(dur);
      cnt = closed_cnt[m] + wlm_pkg::CNT_W'(1);
      closed_cnt[m] = cnt;
      divisor = (window_len == '0) ? wlm_pkg::TOTAL_W'(1) : wlm_pkg::TOTAL_W'(window_len);
      if (cnt != '0 && wlm_pkg::TOTAL_W'(cnt) < divisor) return;
      rep.report_monitor = ev.monitor_index;
      rep.min_duration   = shortest[m];
      rep.max_duration   = longest[m];
      rep.mean_duration  = wlm_pkg::TIME_W'(elapsed_sum[m] / divisor);
      expected_reports.push_back(rep);
      clear_window_stats(m);
   endtask

   function automatic int field_differs(string name, logic [wlm_pkg::TIME_W-1:0] want,
                                        logic [wlm_pkg::TIME_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : watch
      int               errs;
      wlm_pkg::rsp_type want;
      errs = 0;
      if (reset) begin
         window_len = wlm_pkg::WINDOW_LENGTH_RESET;
         for (int m = 0; m < BANK_SIZE; m++) begin
            timing[m]    = 1'b0;
            opened_at[m] = '0;
            clear_window_stats(m);
         end
         expected_reports.delete();
      end else begin
         // Compare the report first: an event taken at this edge cannot report yet.
         if (rsp_valid) begin
            if (expected_reports.size() == 0) begin
               $error("report for monitor %0d with nothing expected",
                      rsp_item.report_monitor);
               errs++;
            end else begin
               want = expected_reports.pop_front();
               errs += field_differs("report_monitor",
                                     wlm_pkg::TIME_W'(want.report_monitor),
                                     wlm_pkg::TIME_W'(rsp_item.report_monitor));
               errs += field_differs("min_duration", want.min_duration,
                                     rsp_item.min_duration);
               errs += field_differs("max_duration", want.max_duration,
                                     rsp_item.max_duration);
               errs += field_differs("mean_duration", want.mean_duration,
                                     rsp_item.mean_duration);
            end
         end
         if (start && !busy) track_event(req_item);
         if (csr_valid && csr_ready) window_len = csr_data;
      end
      mismatch_count      <= mismatch_count + errs;
      reports_outstanding <= expected_reports.size();
   end

endmodule

>>> sim/tb_windowed_latency_monitor_bank.sv
// Testbench top for the windowed latency monitor bank: drives start/stop events
// and window-length writes, and gives the verdict from the wlm_checker count.
// Depends on wlm_pkg, wlm_checker and windowed_latency_monitor_bank.
`timescale 1ns / 1ps

module tb_windowed_latency_monitor_bank;

   localparam int LIMIT_CYCLES    = 250000;
   localparam int ITEMS_PER_PHASE = 54;
   localparam int CALM_PHASE      = 3;
   // Settle long enough for a closing stop and its divide to finish.
   localparam int SETTLE_CYCLES   = 80;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      start     = 1'b0;
   wlm_pkg::req_type          req_item  = '0;
   logic                      csr_valid = 1'b0;
   logic [wlm_pkg::CNT_W-1:0] csr_data  = '0;
   logic                      busy;
   logic                      rsp_valid;
   wlm_pkg::rsp_type          rsp_item;
   logic                      csr_ready;

   int               mismatch_count;
   int               reports_outstanding;
   int               cycle_count = 0;
   int               useful_items = 0;
   bit               calm = 1'b0;
   bit               armed [64];
   logic [wlm_pkg::TIME_W-1:0] now_ticks = '0;

   // Window lengths for the random phases: 1023 followed by 2 closes windows
   // whose count already passed the new, lower length.
   int               phase_lengths [7] = '{4, 1023, 2, 1, 0, 6, 3};

   windowed_latency_monitor_bank DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   wlm_checker wlm_check (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_item            (req_item),
      .rsp_valid           (rsp_valid),
      .rsp_item            (rsp_item),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data),
      .mismatch_count      (mismatch_count),
      .reports_outstanding (reports_outstanding)
   );

   always #5 clock = ~clock;

   // Watchdog: give up well past the slowest legal run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic wlm_pkg::req_type make_item(logic mode, int m,
                                                  logic [wlm_pkg::TIME_W-1:0] t);
      wlm_pkg::req_type it;
      it.mode          = mode;
      it.monitor_index = wlm_pkg::IDX_W'(m);
      it.timestamp     = t;
      return it;
   endfunction

   // Hand one item to the block. Leave start high on return so a back-to-back
   // item keeps it high; only a gap or a drain drops it.
   task automatic issue(wlm_pkg::req_type it);
      int m;
      int gap;
      m   = int'(it.monitor_index);
      gap = 0;
      if (!calm && $urandom_range(0, 99) < 23) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      // Track which monitors are timing; ignored events do not count as work.
      if (it.mode == wlm_pkg::MODE_START && !armed[m]) begin
         armed[m] = 1'b1;
         useful_items++;
      end else if (it.mode == wlm_pkg::MODE_STOP && armed[m]) begin
         armed[m] = 1'b0;
         useful_items++;
      end
   endtask

   task automatic interval(int m, logic [wlm_pkg::TIME_W-1:0] t0,
                           logic [wlm_pkg::TIME_W-1:0] t1);
      issue(make_item(wlm_pkg::MODE_START, m, t0));
      issue(make_item(wlm_pkg::MODE_STOP, m, t1));
   endtask

   // Hold off until every expected report is back and the block has settled.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (reports_outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_window(logic [wlm_pkg::CNT_W-1:0] len);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed start/stop pairs on a small group of monitors so that
   // windows fill up; the rest is noise on any monitor with any mode.
   task automatic random_item(int base);
      int   roll;
      int   m;
      logic mode;
      roll = $urandom_range(0, 99);
      if (roll < 10)
         now_ticks = wlm_pkg::TIME_W'({$urandom(), $urandom()});
      else if (roll < 30)
         now_ticks = now_ticks + wlm_pkg::TIME_W'($urandom());
      else
         now_ticks = now_ticks + wlm_pkg::TIME_W'($urandom_range(0, 1000));
      if ($urandom_range(0, 99) < 75) begin
         m    = base + int'($urandom_range(0, 3));
         mode = armed[m] ? wlm_pkg::MODE_STOP : wlm_pkg::MODE_START;
      end else begin
         m    = $urandom_range(0, 63);
         mode = 1'($urandom_range(0, 1));
      end
      issue(make_item(mode, m, now_ticks));
   endtask

   initial begin
      int target;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset length of 500: a stop on an idle monitor and a repeated start
      // are both dropped, the first stamp stays.
      issue(make_item(wlm_pkg::MODE_STOP, 0, 48'h0));
      issue(make_item(wlm_pkg::MODE_START, 0, 48'h0));
      issue(make_item(wlm_pkg::MODE_START, 0, 48'h64));

      // Length 1: every stop reports.
      set_window(10'd1);
      issue(make_item(wlm_pkg::MODE_STOP, 0, 48'h1234));
      interval(63, 48'hFFFF_FFFF_FFF0, 48'h10);           // timer wraps
      interval(1, 48'h0, 48'hFFFF_FFFF_FFFF);             // longest duration
      interval(2, 48'h5, 48'h5);                          // zero duration
      issue(make_item(wlm_pkg::MODE_STOP, 2, 48'h9));

      // Zero length behaves as one.
      set_window(10'd0);
      interval(3, 48'd100, 48'd350);

      // Three-stop window whose total runs past 48 bits.
      set_window(10'd3);
      interval(5, 48'h0, 48'hFFFF_FFFF_FFFF);
      interval(5, 48'd10, 48'd11);
      interval(5, 48'h0, 48'h8000_0000_0000);

      // Lower the length mid-window: the third stop closes and divides by 1.
      interval(6, 48'h0, 48'd40);
      interval(6, 48'h0, 48'd70);
      set_window(10'd1);
      interval(6, 48'h0, 48'hFFFF_FFFF_FFFF);

      for (int p = 0; p < 7; p++) begin
         set_window(wlm_pkg::CNT_W'(phase_lengths[p]));
         calm   = (p == CALM_PHASE);
         target = useful_items + ITEMS_PER_PHASE;
         begin
            int base;
            base = $urandom_range(0, 60);
            while (useful_items < target) random_item(base);
         end
      end
      calm = 1'b0;

      drain();
      @(negedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
